FILE: rtl/core/wsvt_pkg.sv
`timescale 1ns / 1ps
// wsvt_pkg: shared types and constants for the weekly slot valve timer
// no dependencies; imported by wsvt_ctrl, wsvt_dp and the top level

package wsvt_pkg;

	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	// request kinds
	localparam logic [2:0] REQ_TICK   = 3'd0;
	localparam logic [2:0] REQ_WRITE  = 3'd1;
	localparam logic [2:0] REQ_MODE   = 3'd2;
	localparam logic [2:0] REQ_MANUAL = 3'd3;
	localparam logic [2:0] REQ_STOP   = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FLOW_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd3;

	// configuration reset values
	localparam logic [15:0] FLOW_THR_RST = 16'd20;
	localparam logic [11:0] HOLDOFF_RST  = 12'd30;
	localparam logic [15:0] MAX_RUN_RST  = 16'd3600;
	localparam logic [5:0]  WINDOW_RST   = 6'd5;

	// slot reset values
	localparam logic [4:0]  SLOT_HR_RST   = 5'd6;
	localparam logic [5:0]  SLOT_MN_RST   = 6'd0;
	localparam logic [15:0] SLOT_DUR_RST  = 16'd600;
	localparam logic [6:0]  SLOT_DAYS_RST = 7'd127;

	localparam logic [15:0] CNT16_MAX = 16'hFFFF;
	localparam logic [11:0] AGE_MAX   = 12'hFFF;

	typedef struct packed {
		logic        en;
		logic [4:0]  hr;
		logic [5:0]  mn;
		logic [15:0] dur;
		logic [6:0]  days;
	} slot_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic scan;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_need;
		logic hit;
		logic last;
	} sts_t;

endpackage

FILE: rtl/core/wsvt_ctrl.sv
`timescale 1ns / 1ps
// wsvt_ctrl: sequencing state machine of the weekly slot valve timer
// depends on wsvt_pkg for state, command and status types

module wsvt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  wsvt_pkg::sts_t sts,
	output wsvt_pkg::cmd_t cmd
);
	import wsvt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d = sts.scan_need ? ST_SCAN : ST_RESP;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				cmd.load_out = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

FILE: rtl/core/wsvt_dp.sv
`timescale 1ns / 1ps
// wsvt_dp: slot table, run timer, anomaly limiter and result registers
// depends on wsvt_pkg; driven by wsvt_ctrl commands

module wsvt_dp #(
	parameter int SLOTS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wsvt_pkg::cmd_t                   cmd,
	output wsvt_pkg::sts_t                   sts,
	input  logic                             cfg_we,
	input  logic [wsvt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wsvt_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic [2:0]                       req_type,
	input  logic [2:0]                       weekday,
	input  logic [4:0]                       hour,
	input  logic [5:0]                       minute,
	input  logic [5:0]                       second,
	input  logic                             time_valid,
	input  logic                             valve_closed,
	input  logic [15:0]                      flow_clpm,
	input  logic [2:0]                       slot_index,
	input  logic                             enable_or_manual,
	input  logic [6:0]                       weekday_mask,
	input  logic [15:0]                      duration_sec,
	output logic                             done,
	output logic                             valve_open,
	output logic                             running,
	output logic                             manual_mode,
	output logic [15:0]                      remaining_sec,
	output logic                             anomaly_warning,
	output logic                             slot_started,
	output logic [2:0]                       started_slot
);
	import wsvt_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// configuration
	logic [15:0] flow_thr_q;
	logic [11:0] holdoff_q;
	logic [15:0] max_run_q;
	logic [5:0]  window_q;

	// state
	slot_t       slot_q [SLOTS];
	logic        run_active_q;
	logic        manual_q;
	logic [15:0] run_len_q;
	logic [15:0] elapsed_q;
	logic [11:0] warn_age_q;

	// captured item
	logic [2:0]  req_q;
	logic [2:0]  wd_q;
	logic [4:0]  hr_q;
	logic [5:0]  mn_q;
	logic [5:0]  sec_q;
	logic        tvalid_q;
	logic        vclosed_q;
	logic [15:0] flow_q;
	logic [2:0]  idx_q;
	logic        eom_q;
	logic [6:0]  mask_q;
	logic [15:0] dur_q;

	// per item flags
	logic              warn_q;
	logic              started_q;
	logic [SLOT_W-1:0] which_q;
	logic [SLOT_W-1:0] scan_cnt_q;

	// output registers
	logic        done_q;
	logic        running_q;
	logic        manual_out_q;
	logic [15:0] remain_q;
	logic        warn_out_q;
	logic        started_out_q;
	logic [2:0]  which_out_q;

	logic [15:0]       elapsed_inc;
	logic [11:0]       age_inc;
	logic              idx_ok;
	logic [SLOT_W-1:0] widx;
	slot_t             cur_slot;
	logic [7:0]        days_ext;
	logic              anomaly;

	function automatic logic [15:0] sat_dur(input logic [15:0] d, input logic [15:0] lim);
		sat_dur = (d > lim) ? lim : d;
	endfunction

	assign elapsed_inc = (elapsed_q != CNT16_MAX) ? elapsed_q + 16'd1 : elapsed_q;
	assign age_inc     = (warn_age_q != AGE_MAX) ? warn_age_q + 12'd1 : warn_age_q;
	assign idx_ok      = (32'(idx_q) < SLOTS);
	assign widx        = SLOT_W'(idx_q);
	assign cur_slot    = slot_q[scan_cnt_q];
	assign days_ext    = {1'b0, cur_slot.days};
	assign anomaly     = !run_active_q && vclosed_q && (flow_q > flow_thr_q);

	assign sts.scan_need = (req_q == REQ_TICK) && !run_active_q && !manual_q && tvalid_q;
	assign sts.hit  = cur_slot.en && days_ext[wd_q] && (cur_slot.hr == hr_q) &&
		(cur_slot.mn == mn_q) && (sec_q < window_q);
	assign sts.last = (scan_cnt_q == SLOT_W'(SLOTS - 1));

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_thr_q <= FLOW_THR_RST;
			holdoff_q  <= HOLDOFF_RST;
			max_run_q  <= MAX_RUN_RST;
			window_q   <= WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FLOW_THR: flow_thr_q <= cfg_wdata;
				REG_HOLDOFF:  holdoff_q  <= cfg_wdata[11:0];
				REG_MAX_RUN:  max_run_q  <= cfg_wdata;
				REG_WINDOW:   window_q   <= cfg_wdata[5:0];
				default: begin
				end
			endcase
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q     <= req_type;
			wd_q      <= weekday;
			hr_q      <= hour;
			mn_q      <= minute;
			sec_q     <= second;
			tvalid_q  <= time_valid;
			vclosed_q <= valve_closed;
			flow_q    <= flow_clpm;
			idx_q     <= slot_index;
			eom_q     <= enable_or_manual;
			mask_q    <= weekday_mask;
			dur_q     <= duration_sec;
		end
	end

	// slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_q[i] <= '{en: 1'b0, hr: SLOT_HR_RST, mn: SLOT_MN_RST,
					dur: SLOT_DUR_RST, days: SLOT_DAYS_RST};
			end
		end else if (cmd.exec && (req_q == REQ_WRITE) && idx_ok) begin
			slot_q[widx] <= '{en: eom_q, hr: hr_q, mn: mn_q, dur: dur_q, days: mask_q};
		end
	end

	// run timer, mode and anomaly limiter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_active_q <= 1'b0;
			manual_q     <= 1'b0;
			run_len_q    <= '0;
			elapsed_q    <= '0;
			warn_age_q   <= '0;
			warn_q       <= 1'b0;
			started_q    <= 1'b0;
			which_q      <= '0;
			scan_cnt_q   <= '0;
		end else if (cmd.capture) begin
			warn_q     <= 1'b0;
			started_q  <= 1'b0;
			which_q    <= '0;
			scan_cnt_q <= '0;
		end else if (cmd.exec) begin
			case (req_q)
				REQ_TICK: begin
					warn_age_q <= age_inc;
					if (anomaly && (age_inc >= holdoff_q)) begin
						warn_q     <= 1'b1;
						warn_age_q <= '0;
					end
					if (run_active_q) begin
						elapsed_q <= elapsed_inc;
						if (elapsed_inc >= run_len_q) begin
							run_active_q <= 1'b0;
							manual_q     <= 1'b0;
						end
					end
				end
				REQ_MODE: begin
					manual_q <= eom_q;
				end
				REQ_MANUAL: begin
					run_len_q    <= sat_dur(dur_q, max_run_q);
					elapsed_q    <= '0;
					run_active_q <= 1'b1;
				end
				REQ_STOP: begin
					run_active_q <= 1'b0;
					manual_q     <= 1'b0;
				end
				default: begin
				end
			endcase
		end else if (cmd.scan) begin
			scan_cnt_q <= scan_cnt_q + 1'b1;
			if (sts.hit) begin
				run_len_q    <= sat_dur(cur_slot.dur, max_run_q);
				elapsed_q    <= '0;
				run_active_q <= 1'b1;
				started_q    <= 1'b1;
				which_q      <= scan_cnt_q;
			end
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			running_q     <= run_active_q;
			manual_out_q  <= manual_q;
			remain_q      <= (run_active_q && (elapsed_q < run_len_q)) ?
				run_len_q - elapsed_q : 16'd0;
			warn_out_q    <= warn_q;
			started_out_q <= started_q;
			which_out_q   <= 3'(which_q);
		end
	end

	assign done            = done_q;
	assign valve_open      = running_q;
	assign running         = running_q;
	assign manual_mode     = manual_out_q;
	assign remaining_sec   = remain_q;
	assign anomaly_warning = warn_out_q;
	assign slot_started    = started_out_q;
	assign started_slot    = which_out_q;

endmodule

FILE: rtl/core/weekly_slot_valve_timer.sv
`timescale 1ns / 1ps
// weekly_slot_valve_timer: top level, weekly program slots driving one valve
// depends on wsvt_pkg, wsvt_ctrl and wsvt_dp
//
// usage
//   an item (tick, slot write, mode set, manual start or stop) is taken at a
//   rising edge with start high and busy low; its fields are sampled there
//   every item gives one result: done is high for exactly one cycle with the
//   result fields valid; the receiver cannot hold it off
//   done follows the accepting edge through the EXEC and RESP states of the
//   controller; a tick that scans the slot table also passes through SCAN
//   between them until a slot hits or the last slot is examined; the scan
//   walks one slot per cycle through the single read port of the slot table
//   busy falls as done rises, so the next item can be taken in the done cycle
//   configuration registers are written through cfg_we / cfg_index /
//   cfg_wdata; the user must write them only while the block is idle, which
//   the block itself does not enforce; writes take effect at once
//   reset clears the run timer and mode, loads the register defaults and sets
//   every slot to disabled, 6:00, 600 s, all weekdays; no clearing pass

module weekly_slot_valve_timer #(
	parameter int SLOTS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	output logic                           done,
	input  logic                           cfg_we,
	input  logic [wsvt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wsvt_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [2:0]                     req_type,
	input  logic [2:0]                     weekday,
	input  logic [4:0]                     hour,
	input  logic [5:0]                     minute,
	input  logic [5:0]                     second,
	input  logic                           time_valid,
	input  logic                           valve_closed,
	input  logic [15:0]                    flow_clpm,
	input  logic [2:0]                     slot_index,
	input  logic                           enable_or_manual,
	input  logic [6:0]                     weekday_mask,
	input  logic [15:0]                    duration_sec,
	output logic                           valve_open,
	output logic                           running,
	output logic                           manual_mode,
	output logic [15:0]                    remaining_sec,
	output logic                           anomaly_warning,
	output logic                           slot_started,
	output logic [2:0]                     started_slot
);
	import wsvt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	wsvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	wsvt_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.req_type         (req_type),
		.weekday          (weekday),
		.hour             (hour),
		.minute           (minute),
		.second           (second),
		.time_valid       (time_valid),
		.valve_closed     (valve_closed),
		.flow_clpm        (flow_clpm),
		.slot_index       (slot_index),
		.enable_or_manual (enable_or_manual),
		.weekday_mask     (weekday_mask),
		.duration_sec     (duration_sec),
		.done             (done),
		.valve_open       (valve_open),
		.running          (running),
		.manual_mode      (manual_mode),
		.remaining_sec    (remaining_sec),
		.anomaly_warning  (anomaly_warning),
		.slot_started     (slot_started),
		.started_slot     (started_slot)
	);

endmodule

FILE: rtl/core/wsvt_checker.sv
`timescale 1ns / 1ps
// wsvt_checker: port level assertions for weekly_slot_valve_timer
// bound to the top level below; sees its ports only

module wsvt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        running,
	input logic [15:0] remaining_sec,
	input logic        slot_started,
	input logic [2:0]  started_slot
);

	// accepted item raises busy (its hold until the result is not checked)
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted item");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_idle_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !running) |-> (remaining_sec == 16'd0))
		else $error("remaining time reported while idle");

	a_slot_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(done && slot_started) |-> running)
		else $error("slot start reported without a run");

	a_slot_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !slot_started) |-> (started_slot == 3'd0))
		else $error("slot index set without a slot start");

endmodule

bind weekly_slot_valve_timer wsvt_checker u_wsvt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.running       (running),
	.remaining_sec (remaining_sec),
	.slot_started  (slot_started),
	.started_slot  (started_slot)
);
